// ----- hdl/fcpa_pkg.sv -----
// Shared types and constants of the fixed chunk pool allocator.
package fcpa_pkg;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;

    // Default pool size and count register reset value
    localparam int               DEF_POOL_CHUNKS = 256;
    localparam logic [CFG_W-1:0] CFG_RESET       = 9'd256;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

    // Request beat
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  chunk_index;
    } fcpa_in_t;

    // Result beat
    typedef struct packed {
        logic [IDX_W-1:0]    granted_index;
        logic [STATUS_W-1:0] status;
    } fcpa_out_t;

endpackage

// ----- hdl/fixed_chunk_pool_allocator_core.sv -----
// Fixed chunk pool allocator: free and in-use lists kept in one link memory.
//
// Usage: requests enter on s_valid/s_ready/s_data (mode, chunk_index), one
// result beat per request leaves on m_valid/m_ready/m_data (granted_index,
// status). The chunk count used by a rebuild is written on cfg_valid/cfg_data;
// cfg_ready is always high and the write is meant for idle periods only.
// Steps per request, counted from acceptance to the result being loaded:
//   alloc: read the free head's link, then pop the head onto the in-use list;
//     a request that fails at once (empty pool, empty in-use list) or the
//     unused mode goes straight to the result. free: walk the in-use links,
//     one memory read per link (the single read port sets the pace), then
//     unlink the chunk when found and push it onto the free list
//   rebuild: all POOL_CHUNKS links are rewritten, one link written per cycle
// One request is in flight at a time; s_ready is high only when the control
// sequencer is idle. The result sits in an output register, so the next
// request is taken while a result waits; a stalled receiver only holds the
// sequencer in its final step until the output register frees up.
// Reset: a clearing pass rebuilds the full pool in the link memory;
// s_ready stays low during it, configuration writes are taken.
module fixed_chunk_pool_allocator_core #(
    parameter int POOL_CHUNKS = fcpa_pkg::DEF_POOL_CHUNKS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  fcpa_pkg::fcpa_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fcpa_pkg::fcpa_out_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fcpa_pkg::CFG_W-1:0]   cfg_data
);
    import fcpa_pkg::*;

    localparam int ADDR_W = $clog2(POOL_CHUNKS);
    localparam int LINK_W = $clog2(POOL_CHUNKS + 1);
    localparam int CMP_W  = (LINK_W > IDX_W) ? LINK_W : IDX_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_CHUNKS);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(POOL_CHUNKS - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [LINK_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic              sweep_rst_reg, sweep_rst_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] used_head_reg, used_head_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [ADDR_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0]  target_reg, target_next;
    fcpa_out_t         res_reg, res_next;
    fcpa_out_t         m_data_reg;
    logic              m_valid_reg, m_valid_next;
    logic [CFG_W-1:0]  count_reg;

    // Link memory and its ports
    logic [LINK_W-1:0] link_mem [POOL_CHUNKS];
    logic [LINK_W-1:0] rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [LINK_W-1:0] mem_wdata;

    logic [LINK_W-1:0] eff_count;
    logic [LINK_W-1:0] sweep_plus;
    logic              cur_match;
    logic              out_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Saturate the configured count to the pool size
    assign eff_count = (32'(count_reg) > 32'(POOL_CHUNKS)) ? NULL_LINK
                                                           : LINK_W'(count_reg);
    assign sweep_plus = LINK_W'(sweep_idx_reg) + LINK_W'(1);
    assign cur_match  = (CMP_W'(cur_reg) == CMP_W'(target_reg));
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Link memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= link_mem[mem_raddr];
        end
    end

    // Sequencer: read, modify and write back the lists. No read is issued in
    // a cycle that writes, so no forwarding.
    always_comb begin
        state_next     = state_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_cnt_next = sweep_cnt_reg;
        sweep_rst_next = sweep_rst_reg;
        free_head_next = free_head_reg;
        used_head_next = used_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.mode)
                        MODE_REBUILD: begin
                            sweep_idx_next = '0;
                            sweep_cnt_next = eff_count;
                            sweep_rst_next = 1'b0;
                            state_next     = ST_SWEEP;
                        end
                        MODE_ALLOC: begin
                            if (free_head_reg < NULL_LINK) begin
                                mem_re     = 1'b1;
                                mem_raddr  = free_head_reg[ADDR_W-1:0];
                                cur_next   = free_head_reg;
                                state_next = ST_ALLOC;
                            end else begin
                                res_next   = '{granted_index: '0, status: STATUS_EMPTY};
                                state_next = ST_DONE;
                            end
                        end
                        MODE_FREE: begin
                            target_next = s_data.chunk_index;
                            if (used_head_reg < NULL_LINK) begin
                                mem_re     = 1'b1;
                                mem_raddr  = used_head_reg[ADDR_W-1:0];
                                cur_next   = used_head_reg;
                                prev_next  = NULL_LINK;
                                steps_next = '0;
                                state_next = ST_WALK;
                            end else begin
                                res_next   = '{granted_index: '0, status: STATUS_NOT_USED};
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            res_next   = '{granted_index: '0, status: STATUS_OK};
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Link each chunk to its successor if that is below the count, else to null
                mem_we    = 1'b1;
                mem_waddr = sweep_idx_reg;
                mem_wdata = (sweep_plus < sweep_cnt_reg) ? sweep_plus : NULL_LINK;
                if (sweep_idx_reg == LAST_IDX) begin
                    free_head_next = (sweep_cnt_reg != '0) ? '0 : NULL_LINK;
                    used_head_next = NULL_LINK;
                    res_next       = '{granted_index: '0, status: STATUS_OK};
                    state_next     = sweep_rst_reg ? ST_IDLE : ST_DONE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + ADDR_W'(1);
                end
            end
            ST_ALLOC: begin
                // Pop the free head, push it onto the in-use list
                free_head_next = rdata_reg;
                mem_we         = 1'b1;
                mem_waddr      = cur_reg[ADDR_W-1:0];
                mem_wdata      = used_head_reg;
                used_head_next = cur_reg;
                res_next       = '{granted_index: IDX_W'(cur_reg[ADDR_W-1:0]),
                                   status: STATUS_OK};
                state_next     = ST_DONE;
            end
            ST_WALK: begin
                // rdata holds the link of the current chunk
                if (cur_match) begin
                    if (prev_reg >= NULL_LINK) begin
                        used_head_next = rdata_reg;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = prev_reg[ADDR_W-1:0];
                        mem_wdata = rdata_reg;
                    end
                    state_next = ST_PUSH;
                end else if ((rdata_reg >= NULL_LINK) || (steps_reg == LAST_IDX)) begin
                    res_next   = '{granted_index: '0, status: STATUS_NOT_USED};
                    state_next = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = rdata_reg[ADDR_W-1:0];
                    prev_next  = cur_reg;
                    cur_next   = rdata_reg;
                    steps_next = steps_reg + ADDR_W'(1);
                end
            end
            ST_PUSH: begin
                // Push the released chunk onto the free head
                mem_we         = 1'b1;
                mem_waddr      = cur_reg[ADDR_W-1:0];
                mem_wdata      = free_head_reg;
                free_head_next = cur_reg;
                res_next       = '{granted_index: '0, status: STATUS_OK};
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until the receiver takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_idx_reg <= '0;
            sweep_cnt_reg <= NULL_LINK;
            sweep_rst_reg <= 1'b1;
            free_head_reg <= '0;
            used_head_reg <= NULL_LINK;
            m_valid_reg   <= 1'b0;
            count_reg     <= CFG_RESET;
        end else begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_cnt_reg <= sweep_cnt_next;
            sweep_rst_reg <= sweep_rst_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        target_reg <= target_next;
        res_reg    <= res_next;
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    // Every accepted request leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start the sequencer");

    // The two lists never share a head chunk
    a_heads_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg != used_head_reg) || (free_head_reg == NULL_LINK))
        else $error("free and in-use lists share a head");

    // A result beat appears only after the final step
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside the final step");

    // A successful alloc lands on the in-use head
    a_alloc_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC) |=> (used_head_reg == $past(cur_reg)))
        else $error("allocated chunk not pushed onto in-use list");
`endif

endmodule

// ----- verif/fixed_chunk_pool_allocator_core_test.sv -----
// Self-checking testbench for the fixed chunk pool allocator core.
module fixed_chunk_pool_allocator_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fcpa_pkg::*;

    localparam int               POOL        = DEF_POOL_CHUNKS;
    localparam int               NULL_LINK   = POOL;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;
    localparam int               RAND_ITEMS  = 1250;
    localparam int               QUIET_TAIL  = 150;
    localparam int               CYCLE_LIMIT = 1_500_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    fcpa_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    fcpa_out_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Pool model: one link store shared by the free and in-use lists
    logic [8:0]   link_mem [POOL];
    int           free_hd;
    int           used_hd;
    logic [CFG_W-1:0] count_reg;

    fcpa_in_t     req_q [$];
    fcpa_out_t    result_q [$];
    int           n_pushed   = 0;
    int           n_accepted = 0;
    int           n_checked  = 0;
    int           n_fail     = 0;
    int           cycle_cnt  = 0;

    int           idle_pct = 0;
    bit           quiet    = 1'b0;
    int           tx_hold  = 0;
    int           rx_hold  = 0;

    int           n_rebuild = 0;
    int           n_grant   = 0;
    int           n_empty   = 0;
    int           n_release = 0;
    int           n_reject  = 0;
    int           n_cfg     = 0;

    fixed_chunk_pool_allocator_core #(
        .POOL_CHUNKS(POOL)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Link chunks 0 .. count-1 onto the free list and empty the in-use list
    task automatic relink_pool();
        int n;
        n = (count_reg > POOL) ? POOL : int'(count_reg);
        for (int i = 0; i < POOL; i++) begin
            link_mem[i] = (i + 1 < n) ? 9'(i + 1) : 9'(NULL_LINK);
        end
        free_hd = (n > 0) ? 0 : NULL_LINK;
        used_hd = NULL_LINK;
    endtask

    // Apply one request to the pool model and queue the result it yields
    task automatic serve_request(input fcpa_in_t req);
        fcpa_out_t res;
        int        cur;
        int        prev;
        int        nxt;
        int        steps;
        bit        found;
        res = '0;
        res.status = STATUS_OK;
        case (req.mode)
            MODE_REBUILD: begin
                relink_pool();
                n_rebuild++;
            end
            MODE_ALLOC: begin
                if (free_hd >= POOL) begin
                    res.status = STATUS_EMPTY;
                    n_empty++;
                end else begin
                    cur = free_hd;
                    free_hd = int'(link_mem[cur]);
                    link_mem[cur] = 9'(used_hd);
                    used_hd = cur;
                    res.granted_index = cur[IDX_W-1:0];
                    n_grant++;
                end
            end
            MODE_FREE: begin
                cur = used_hd;
                prev = NULL_LINK;
                steps = 0;
                found = 1'b0;
                while (!found && cur < POOL && steps < POOL) begin
                    nxt = int'(link_mem[cur]);
                    if (cur == int'(req.chunk_index)) begin
                        if (prev >= POOL) begin
                            used_hd = nxt;
                        end else begin
                            link_mem[prev] = 9'(nxt);
                        end
                        link_mem[cur] = 9'(free_hd);
                        free_hd = cur;
                        found = 1'b1;
                    end else begin
                        prev = cur;
                        cur = nxt;
                        steps++;
                    end
                end
                if (found) begin
                    n_release++;
                end else begin
                    res.status = STATUS_NOT_USED;
                    n_reject++;
                end
            end
            default: ;
        endcase
        result_q.push_back(res);
    endtask

    // Pick a random member of a list, or -1 when the list is empty
    function automatic int pick_member(input int head);
        int cur;
        int len;
        int k;
        cur = head;
        len = 0;
        while (cur < POOL && len < POOL) begin
            cur = int'(link_mem[cur]);
            len++;
        end
        if (len == 0) begin
            return -1;
        end
        k = $urandom_range(len - 1, 0);
        cur = head;
        repeat (k) cur = int'(link_mem[cur]);
        return cur;
    endfunction

    // Hand one request to the driver and hold until it is taken
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
        fcpa_in_t req;
        req.mode = mode;
        req.chunk_index = idx;
        req_q.push_back(req);
        n_pushed++;
        wait (n_accepted == n_pushed);
    endtask

    // Write the chunk count once every result is back
    task automatic write_count(input logic [CFG_W-1:0] value);
        wait (n_checked == n_pushed);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg = value;
        n_cfg++;
    endtask

    // Request driver: present queued beats, with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_hold = 0;
        end else begin
            if (s_valid && s_ready) begin
                serve_request(s_data);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                    s_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_data  <= req_q.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(99, 0) < idle_pct) begin
                        tx_hold = $urandom_range(9, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest expectation, stall at random
    always @(posedge aclk) begin
        fcpa_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with no request pending: granted_index %0d status %0d",
                           m_data.granted_index, m_data.status);
                    n_fail++;
                end else begin
                    want = result_q.pop_front();
                    n_checked++;
                    if (m_data.granted_index !== want.granted_index) begin
                        $error("granted_index: expected %0d, got %0d",
                               want.granted_index, m_data.granted_index);
                        n_fail++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        n_fail++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
            end else if (!quiet && $urandom_range(99, 0) < idle_pct) begin
                rx_hold = $urandom_range(9, 1);
            end
            m_ready <= (rx_hold == 0);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("fixed_chunk_pool_allocator_core_test failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int n_rand;
        int r;
        int s;
        int pick;
        int len;
        logic [CFG_W-1:0] cnt;

        count_reg = CFG_RESET;
        relink_pool();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Pool as left by reset: full count, nothing in use
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_ALLOC, 8'hFF);
        issue(MODE_FREE, 8'd0);
        issue(MODE_FREE, 8'd0);
        issue(MODE_FREE, 8'd255);
        issue(MODE_NOP, 8'hFF);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_FREE, 8'd1);
        issue(MODE_FREE, 8'd0);

        // Count zero: empty pool after rebuild
        write_count(9'd0);
        issue(MODE_REBUILD, 8'd0);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_FREE, 8'd0);

        // Count above the pool size saturates
        write_count(9'h1FF);
        issue(MODE_REBUILD, 8'hFF);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_FREE, 8'd0);

        // Single chunk: drain it, then free one beyond the count
        write_count(9'd1);
        issue(MODE_REBUILD, 8'd0);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_FREE, 8'd0);
        issue(MODE_FREE, 8'd200);

        // Full pool: free the tail of the in-use list
        write_count(9'd256);
        issue(MODE_REBUILD, 8'd255);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_ALLOC, 8'd0);
        issue(MODE_FREE, 8'd0);

        // Random phases: new count, rebuild, then mixed alloc/free traffic
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            r = $urandom_range(99, 0);
            if (r < 3) begin
                cnt = 9'd0;
            end else if (r < 8) begin
                cnt = 9'($urandom_range(511, 257));
            end else if (r < 15) begin
                cnt = 9'd256;
            end else if (r < 40) begin
                cnt = 9'($urandom_range(8, 1));
            end else begin
                cnt = 9'($urandom_range(255, 1));
            end
            write_count(cnt);
            case ($urandom_range(2, 0))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            issue(MODE_REBUILD, 8'($urandom));
            n_rand++;
            len = $urandom_range(80, 20);
            repeat (len) begin
                r = $urandom_range(99, 0);
                if (r < 45) begin
                    issue(MODE_ALLOC, 8'($urandom));
                    n_rand++;
                end else if (r < 87) begin
                    s = $urandom_range(99, 0);
                    if (s < 70) begin
                        pick = pick_member(used_hd);
                    end else if (s < 85) begin
                        pick = pick_member(free_hd);
                    end else begin
                        pick = -1;
                    end
                    if (pick < 0) begin
                        pick = $urandom_range(255, 0);
                    end
                    issue(MODE_FREE, 8'(pick));
                    n_rand++;
                end else if (r < 93) begin
                    issue(MODE_REBUILD, 8'($urandom));
                    n_rand++;
                end else begin
                    issue(MODE_NOP, 8'($urandom));
                end
            end
            if (n_rand >= RAND_ITEMS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
        end

        // Drain outstanding results, then settle
        wait (n_checked == n_pushed);
        repeat (16) @(posedge aclk);

        $display("Covered %0d requests over %0d count settings: %0d rebuilds, %0d grants, %0d empty",
                 n_pushed, n_cfg, n_rebuild, n_grant, n_empty);
        $display("Releases: %0d accepted, %0d rejected as not in use; %0d results checked",
                 n_release, n_reject, n_checked);
        if (n_fail == 0 && result_q.size() == 0) begin
            $display("fixed_chunk_pool_allocator_core_test passed");
        end else begin
            $display("fixed_chunk_pool_allocator_core_test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fcpa_pkg.sv
hdl/fixed_chunk_pool_allocator_core.sv
verif/fixed_chunk_pool_allocator_core_test.sv
